@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDE_W = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_G1_START,
        S_G1_WAIT,
        S_Q1_START,
        S_Q1_WAIT,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_G2_START,
        S_G2_WAIT,
        S_QN_START,
        S_QN_WAIT,
        S_QD_START,
        S_QD_WAIT,
        S_FIX,
        S_RND_START,
        S_RND_WAIT,
        S_DONE
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quot;
        logic [WIDE_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/rau_divider.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    logic [WIDE_W-1:0] quot_reg, quot_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] dvs_reg, dvs_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WIDE_W:0]   trial;
    logic [WIDE_W:0]   diff;

    always_comb
    begin
        trial      = {rem_reg, quot_reg[WIDE_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'(WIDE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDE_W])
            begin
                rem_next  = diff[WIDE_W-1:0];
                quot_next = {quot_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[WIDE_W-1:0];
                quot_next = {quot_reg[WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions, reduces the result and rounds it.
// ----------------------------------------------------------------------------
//  Channel  Handshake          Payload
//  input    in_valid/in_ready  cmd, a_num, a_den, b_num, b_den
//  output   out_valid/out_ready res_num, res_den, rounded, status
//
//  A word with a zero denominator goes from S_CHECK straight to S_DONE; any
//  other word takes one divider pass per Euclid step of each gcd, one per
//  quotient by a gcd and, when the status is ok, one for rounding, all on the
//  single shared bit-serial divider.
//  Reset clears the sequencer and the divider control only; no clearing pass
//  is needed.
//  The block takes no new word until the result has been taken.
module rational_arithmetic_unit
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] res_num,
    output logic [30:0] res_den,
    output logic signed [31:0] rounded,
    output logic [1:0]  status
);
    import rau_pkg::*;

    localparam logic [WIDE_W-1:0] VTOP = WIDE_W'(1) << (VALUE_WIDTH - 1);

    state_t state_reg, state_next;
    div_req_t req;
    div_rsp_t rsp;

    logic [1:0]        cmd_reg;
    logic              an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [31:0]       an_reg, ad_reg, bn_reg, bd_reg;
    logic [WIDE_W-1:0] x_reg, y_reg, g_reg, adg_reg, bdg_reg;
    logic [WIDE_W-1:0] nm_reg, dm_reg, t1_reg, t2_reg;
    logic              neg_reg, t1n_reg, t2n_reg;
    logic [1:0]        st_reg;
    logic signed [31:0] rn_reg, rr_reg;
    logic [30:0]       rd_reg;
    logic [WIDE_W-1:0] mul_a, mul_b, mul_p;
    logic [WIDE_W-1:0] rnd_mag;

    function automatic logic [32:0] to_smag(input logic [31:0] raw);
        logic [31:0] v;
        logic        s;
        begin
            v = raw & 32'((64'(1) << VALUE_WIDTH) - 1);
            s = v[VALUE_WIDTH-1];
            if (s)
                v = (~v + 32'd1) & 32'((64'(1) << VALUE_WIDTH) - 1);
            to_smag = {s, v};
        end
    endfunction

    // Single shared 32x32 multiplier; operands always fit 32 bits.
    assign mul_p = 64'(mul_a[31:0]) * 64'(mul_b[31:0]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL1:  begin mul_a = 64'(an_reg); mul_b = (cmd_reg == CMD_DIV) ? 64'(bd_reg)
                           : (cmd_reg == CMD_MUL) ? 64'(bn_reg) : bdg_reg; end
            S_MUL2:  begin mul_a = 64'(bn_reg); mul_b = adg_reg; end
            S_MUL3:  begin mul_a = (cmd_reg == CMD_DIV) ? 64'(bn_reg) :
                           (cmd_reg == CMD_MUL) ? 64'(bd_reg) : adg_reg;
                           mul_b = (cmd_reg == CMD_MUL || cmd_reg == CMD_DIV) ?
                           64'(ad_reg) : 64'(bd_reg); end
            default: ;
        endcase
    end

    // Rounding dividend magnitude: |n + d/2|.
    always_comb
    begin
        if (!neg_reg)
            rnd_mag = nm_reg + (dm_reg >> 1);
        else if (nm_reg >= (dm_reg >> 1))
            rnd_mag = nm_reg - (dm_reg >> 1);
        else
            rnd_mag = (dm_reg >> 1) - nm_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (ad_reg == 0 || bd_reg == 0 || (cmd_reg == CMD_DIV && bn_reg == 0))
                    state_next = S_DONE;
                else if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                    state_next = S_G1_START;
                else
                    state_next = S_MUL1;
            end
            S_G1_START:  state_next = (y_reg == 0) ? S_Q1_START : S_G1_WAIT;
            S_G1_WAIT:   if (rsp.done) state_next = S_G1_START;
            S_Q1_START:  state_next = S_Q1_WAIT;
            S_Q1_WAIT:   if (rsp.done) state_next = (adg_reg == '1) ? S_Q1_START : S_MUL1;
            S_MUL1:      state_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ? S_MUL2 : S_MUL3;
            S_MUL2:      state_next = S_MUL3;
            S_MUL3:      state_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ? S_SUM : S_G2_START;
            S_SUM:       state_next = S_G2_START;
            S_G2_START:  state_next = (y_reg == 0) ? S_QN_START : S_G2_WAIT;
            S_G2_WAIT:   if (rsp.done) state_next = S_G2_START;
            S_QN_START:  state_next = S_QN_WAIT;
            S_QN_WAIT:   if (rsp.done) state_next = S_QD_START;
            S_QD_START:  state_next = S_QD_WAIT;
            S_QD_WAIT:   if (rsp.done) state_next = S_FIX;
            S_FIX:       state_next = (st_reg != ST_OK) ? S_DONE : S_RND_START;
            S_RND_START: state_next = S_RND_WAIT;
            S_RND_WAIT:  if (rsp.done) state_next = S_DONE;
            S_DONE:      if (out_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req = '0;
        case (state_reg)
            S_G1_START, S_G2_START:
            begin
                req.start    = (y_reg != 0);
                req.dividend = x_reg;
                req.divisor  = y_reg;
            end
            S_Q1_START:
            begin
                req.start    = 1'b1;
                req.dividend = (adg_reg == '1) ? 64'(ad_reg) : 64'(bd_reg);
                req.divisor  = g_reg;
            end
            S_QN_START:
            begin
                req.start = 1'b1; req.dividend = nm_reg; req.divisor = g_reg;
            end
            S_QD_START:
            begin
                req.start = 1'b1; req.dividend = dm_reg; req.divisor = g_reg;
            end
            S_RND_START:
            begin
                req.start = 1'b1; req.dividend = rnd_mag; req.divisor = dm_reg;
            end
            default: ;
        endcase
    end

    rau_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= cmd;
                {an_s_reg, an_reg} <= to_smag(a_num);
                {ad_s_reg, ad_reg} <= to_smag(a_den);
                {bn_s_reg, bn_reg} <= to_smag(b_num);
                {bd_s_reg, bd_reg} <= to_smag(b_den);
                st_reg <= ST_OK;
            end
            S_CHECK:
            begin
                x_reg   <= 64'(ad_reg);
                y_reg   <= 64'(bd_reg);
                adg_reg <= '1;
                if (ad_reg == 0 || bd_reg == 0 || (cmd_reg == CMD_DIV && bn_reg == 0))
                    st_reg <= ST_ZERO_DEN;
                if (cmd_reg == CMD_SUB)
                    bn_s_reg <= ~bn_s_reg;
            end
            S_G1_START, S_G2_START:
                if (y_reg == 0) g_reg <= x_reg;
            S_G1_WAIT, S_G2_WAIT:
                if (rsp.done)
                begin
                    x_reg <= y_reg;
                    y_reg <= rsp.rem;
                end
            S_Q1_WAIT:
                if (rsp.done)
                begin
                    if (adg_reg == '1) adg_reg <= rsp.quot;
                    else bdg_reg <= rsp.quot;
                end
            S_MUL1:
            begin
                t1_reg  <= mul_p;
                t1n_reg <= an_s_reg ^ bd_s_reg;
                if (cmd_reg == CMD_MUL)
                    neg_reg <= an_s_reg ^ bn_s_reg ^ ad_s_reg ^ bd_s_reg;
                else if (cmd_reg == CMD_DIV)
                    neg_reg <= an_s_reg ^ bd_s_reg ^ ad_s_reg ^ bn_s_reg;
                nm_reg <= mul_p;
            end
            S_MUL2:
            begin
                t2_reg  <= mul_p;
                t2n_reg <= bn_s_reg ^ ad_s_reg;
            end
            S_MUL3:
            begin
                dm_reg <= mul_p;
                x_reg  <= nm_reg;
                y_reg  <= mul_p;
            end
            S_SUM:
            begin
                if (t1n_reg == t2n_reg)
                begin
                    nm_reg  <= t1_reg + t2_reg;
                    x_reg   <= t1_reg + t2_reg;
                    neg_reg <= t1n_reg ^ ad_s_reg ^ bd_s_reg;
                end
                else if (t1_reg >= t2_reg)
                begin
                    nm_reg  <= t1_reg - t2_reg;
                    x_reg   <= t1_reg - t2_reg;
                    neg_reg <= t1n_reg ^ ad_s_reg ^ bd_s_reg;
                end
                else
                begin
                    nm_reg  <= t2_reg - t1_reg;
                    x_reg   <= t2_reg - t1_reg;
                    neg_reg <= t2n_reg ^ ad_s_reg ^ bd_s_reg;
                end
                y_reg <= dm_reg;
            end
            S_QN_WAIT: if (rsp.done) nm_reg <= rsp.quot;
            S_QD_WAIT: if (rsp.done) dm_reg <= rsp.quot;
            S_FIX:
            begin
                // A zero numerator reduces to 0/1 with a positive sign.
                if (nm_reg == 0)
                begin
                    neg_reg <= 1'b0;
                    dm_reg  <= 64'd1;
                end
                else if ((neg_reg ? nm_reg > VTOP : nm_reg > VTOP - 1) || dm_reg > VTOP - 1)
                    st_reg <= ST_RANGE;
                rn_reg <= neg_reg ? -32'(nm_reg) : 32'(nm_reg);
                rd_reg <= (nm_reg == 0) ? 31'd1 : 31'(dm_reg);
            end
            S_RND_WAIT:
                if (rsp.done)
                    rr_reg <= (neg_reg && nm_reg > (dm_reg >> 1)) ? -32'(rsp.quot)
                            : 32'(rsp.quot);
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign status    = st_reg;
    assign res_num   = (st_reg == ST_OK) ? rn_reg : '0;
    assign res_den   = (st_reg == ST_OK) ? rd_reg : '0;
    assign rounded   = (st_reg == ST_OK) ? rr_reg : '0;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready and valid together");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !(state_reg == S_IDLE || state_reg == S_DONE))
        else $error("divider started outside work");
    a_den_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> res_den != 0)
        else $error("zero denominator with ok status");

endmodule

@@ bench/rational_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction operations through the valid/ready handshake with random
// idling on both sides. A directed table covers the extremes, every operation
// and the zero-denominator and range cases, then random words follow. Typed
// rows are checked against the table, all others against a fraction predictor.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

    import rau_pkg::*;

    localparam int  VW          = 32;
    localparam int  RANDOM_WORDS = 1400;
    localparam int  CYCLE_LIMIT = 60_000_000;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic signed [31:0] rnd;
        status_t            st;
    } fraction_t;

    typedef struct {
        cmd_t        op;
        logic [31:0] an, ad, bn, bd;
        bit          typed;
        fraction_t   want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = CMD_ADD;
    logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic signed [31:0] rounded;
    logic [1:0] status;

    fraction_t expected_results[$];
    fraction_t typed_want;
    bit        typed_pending = 1'b0;
    int        accepted_words = 0;
    int        mismatches = 0;
    longint    cycles = 0;

    rational_arithmetic_unit #(.VALUE_WIDTH(VW)) dut (.*);

    always #4 clk = ~clk;

    function automatic logic [63:0] magnitude(logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? -v : v;
        return {32'b0, m};
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_t rational_result(cmd_t op, logic [31:0] an, logic [31:0] ad,
                                                  logic [31:0] bn, logic [31:0] bd);
        logic [63:0] anm, adm, bnm, bdm, g, t1m, t2m, nm, dm;
        logic        bns, t1s, t2s, ss, neg;
        longint      n, d, r;
        fraction_t   f;
        anm = magnitude(an);
        adm = magnitude(ad);
        bnm = magnitude(bn);
        bdm = magnitude(bd);
        bns = bn[31];
        neg = 1'b0;
        nm = '0;
        dm = '0;
        f = '{num: '0, den: '0, rnd: '0, st: ST_OK};
        if (adm == 0 || bdm == 0 || (op == CMD_DIV && bnm == 0))
            f.st = ST_ZERO_DEN;
        else if (op == CMD_ADD || op == CMD_SUB)
        begin
            g = gcd64(adm, bdm);
            if (op == CMD_SUB)
                bns = ~bns;
            t1s = an[31] ^ bd[31];
            t1m = anm * (bdm / g);
            t2s = bns ^ ad[31];
            t2m = bnm * (adm / g);
            if (t1s == t2s)
            begin
                ss = t1s;
                nm = t1m + t2m;
            end
            else if (t1m >= t2m)
            begin
                ss = t1s;
                nm = t1m - t2m;
            end
            else
            begin
                ss = t2s;
                nm = t2m - t1m;
            end
            dm = (adm / g) * bdm;
            neg = ss ^ ad[31] ^ bd[31];
        end
        else if (op == CMD_MUL)
        begin
            nm = anm * bnm;
            dm = adm * bdm;
            neg = an[31] ^ bn[31] ^ ad[31] ^ bd[31];
        end
        else
        begin
            nm = anm * bdm;
            dm = adm * bnm;
            neg = an[31] ^ bd[31] ^ ad[31] ^ bn[31];
        end
        if (f.st == ST_OK)
        begin
            g = gcd64(nm, dm);
            nm = nm / g;
            dm = dm / g;
            if (nm == 0)
            begin
                neg = 1'b0;
                dm = 1;
            end
            if ((neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF) || dm > 64'h7FFF_FFFF)
                f.st = ST_RANGE;
            else
            begin
                n = neg ? -longint'(nm) : longint'(nm);
                d = longint'(dm);
                r = (n + d / 2) / d;
                f.num = n[31:0];
                f.den = dm[30:0];
                f.rnd = r[31:0];
            end
        end
        return f;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [31:0] random_operand(bit is_den);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return is_den ? 32'($signed($urandom_range(0, 40)) - 20)
                          : 32'($signed($urandom_range(0, 200)) - 100);
        else if (r < 85)
            return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
        return $urandom;
    endfunction

    always @(posedge clk)
    begin
        fraction_t e;
        if (rst_n)
            cycles <= cycles + 1;
        if (in_valid && in_ready)
        begin
            if (typed_pending)
                expected_results.push_back(typed_want);
            else
                expected_results.push_back(rational_result(cmd_t'(cmd), a_num, a_den,
                                                           b_num, b_den));
            accepted_words <= accepted_words + 1;
        end
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: num %0d den %0d rnd %0d status %0d",
                             res_num, res_den, rounded, status);
            end
            else
            begin
                e = expected_results.pop_front();
                if (res_num !== e.num || res_den !== e.den || rounded !== e.rnd
                    || status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected %0d/%0d rnd %0d status %0d, ",
                                  "got %0d/%0d rnd %0d status %0d"},
                                 e.num, e.den, e.rnd, e.st, res_num, res_den, rounded,
                                 status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: ready in runs, with stalls of random length between them.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            stall = idle_length();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    task automatic send_word(cmd_t op, logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                             logic [31:0] bd, bit typed, fraction_t want, bit calm);
        int gap;
        int seen;
        gap = calm ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd = op;
        a_num = an;
        a_den = ad;
        b_num = bn;
        b_den = bd;
        typed_pending = typed;
        typed_want = want;
        in_valid = 1'b1;
        seen = accepted_words;
        do
            @(negedge clk);
        while (accepted_words == seen);
    endtask

    initial
    begin
        stim_row_t rows[$];
        fraction_t none;
        logic [31:0] an, ad, bn, bd;
        none = '{num: '0, den: '0, rnd: '0, st: ST_OK};
        rows = '{
            '{CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1, '{32'sd5, 31'd6, 32'sd1, ST_OK}},
            '{CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1, '{32'sd0, 31'd1, 32'sd0, ST_OK}},
            '{CMD_MUL, 32'd2, 32'd3, 32'd3, 32'd4, 1, '{32'sd1, 31'd2, 32'sd1, ST_OK}},
            '{CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 1, '{32'sd0, 31'd0, 32'sd0, ST_ZERO_DEN}},
            '{CMD_ADD, 32'd1, 32'd0, 32'd3, 32'd4, 1, '{32'sd0, 31'd0, 32'sd0, ST_ZERO_DEN}},
            '{CMD_MUL, 32'd7, 32'd1, 32'd9, 32'd0, 1, '{32'sd0, 31'd0, 32'sd0, ST_ZERO_DEN}},
            '{CMD_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1,
              '{32'sd0, 31'd0, 32'sd0, ST_RANGE}},
            '{CMD_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1, 1,
              '{32'sh8000_0000, 31'd1, 32'sh8000_0000, ST_OK}},
            '{CMD_SUB, 32'd0, 32'd1, 32'h8000_0000, 32'd1, 1,
              '{32'sd0, 31'd0, 32'sd0, ST_RANGE}},
            '{CMD_DIV, -32'sd7, 32'd2, 32'd1, 32'd1, 1, '{-32'sd7, 31'd2, -32'sd3, ST_OK}},
            '{CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
              '{32'sd1, 31'd1, 32'sd1, ST_OK}},
            '{CMD_DIV, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 1,
              '{-32'sh7FFF_FFFF, 31'd1, -32'sh7FFF_FFFF, ST_OK}},
            '{CMD_DIV, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 0, none},
            '{CMD_ADD, -32'sd3, -32'sd4, 32'd5, -32'sd6, 0, none},
            '{CMD_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE, 0, none},
            '{CMD_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none},
            '{CMD_MUL, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 0, none},
            '{CMD_DIV, 32'h8000_0000, 32'd3, 32'h8000_0000, 32'd7, 0, none},
            '{CMD_SUB, 32'd10, 32'd4, -32'sd3, 32'd6, 0, none}
        };
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i])
            send_word(rows[i].op, rows[i].an, rows[i].ad, rows[i].bn, rows[i].bd,
                      rows[i].typed, rows[i].want, 1'b0);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            an = random_operand(1'b0);
            ad = random_operand(1'b1);
            bn = random_operand(1'b0);
            bd = random_operand(1'b1);
            // Every few hundred words a stretch runs back to back.
            send_word(cmd_t'($urandom_range(0, 3)), an, ad, bn, bd, 1'b0, none,
                      (i % 300) < 40);
        end
        in_valid = 1'b0;
        typed_pending = 1'b0;
        wait (expected_results.size() == 0);
        repeat (200) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
